// ----- rtl/core/dsau_pkg.sv -----
// Shared types, constants and helpers of the decimal scaled arithmetic unit.
// No dependencies; imported by the multiplier, the divider and the top level.
`default_nettype none
package dsau_pkg;

	localparam int POW_N = 64;
	typedef logic [63:0] pow_tab_t [POW_N];

	// 10^n wrapped to 64 bits; entries above 10^19 no longer fit
	function automatic pow_tab_t gen_pow10();
		pow_tab_t t;
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < POW_N; i++) begin
			t[i] = p;
			p = p * 64'd10;
		end
		return t;
	endfunction

	localparam pow_tab_t POW10 = gen_pow10();
	localparam logic [5:0] POW_MAX_EXP = 6'd19;

	localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MASK63   = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [3:0] CMD_ADD = 4'd0;
	localparam logic [3:0] CMD_SUB = 4'd1;
	localparam logic [3:0] CMD_MUL = 4'd2;
	localparam logic [3:0] CMD_DIV = 4'd3;
	localparam logic [3:0] CMD_EQ  = 4'd4;
	localparam logic [3:0] CMD_GT  = 4'd5;
	localparam logic [3:0] CMD_LT  = 4'd6;
	localparam logic [3:0] CMD_GE  = 4'd7;
	localparam logic [3:0] CMD_LE  = 4'd8;

	// request to one of the shared iterative arithmetic units
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} arith_req_t;

	function automatic logic [63:0] mag_of(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// product does not fit a signed 64-bit value of the given sign
	function automatic logic mul_ovf(input logic [127:0] p, input logic neg);
		return (p[127:64] != 64'd0) || (p[63:0] > (neg ? SIGN_BIT : MASK63));
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/dsau_mul.sv -----
// Iterative 64x64 unsigned multiplier built on one 32x32 multiplier.
// Depends on dsau_pkg (arith_req_t).
`default_nettype none
module dsau_mul import dsau_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire arith_req_t   req,
	output logic              done,
	output logic [127:0]      prod
);

	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic [63:0]  pp_s1;
	logic [127:0] acc_q;
	logic [1:0]   pp_step;
	logic [31:0]  a_half, b_half;
	logic [1:0]   sh_step;
	logic [127:0] pp_shifted;

	assign pp_step = cnt_q[1:0];
	assign a_half  = pp_step[0] ? a_q[63:32] : a_q[31:0];
	assign b_half  = pp_step[1] ? b_q[63:32] : b_q[31:0];
	assign sh_step = cnt_q[1:0] - 2'd1;

	always_comb begin
		pp_shifted = {64'd0, pp_s1};
		case ({1'b0, sh_step[0]} + {1'b0, sh_step[1]})
			2'd1:    pp_shifted = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_shifted = {pp_s1, 64'd0};
			default: pp_shifted = {64'd0, pp_s1};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= 128'd0;
		end else if (run_q) begin
			if (cnt_q < 3'd4)
				pp_s1 <= a_half * b_half;
			if (cnt_q != 3'd0)
				acc_q <= acc_q + pp_shifted;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

// ----- rtl/core/dsau_div.sv -----
// Iterative 64-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on dsau_pkg (arith_req_t).
`default_nettype none
module dsau_div import dsau_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire arith_req_t  req,
	output logic             done,
	output logic [63:0]      quot,
	output logic [63:0]      rem
);

	logic [63:0] q_q, r_q, d_q;
	logic [6:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [64:0] shifted;
	logic [64:0] trial;

	assign shifted = {r_q, q_q[63]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= 7'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.a;
			d_q <= req.b;
			r_q <= 64'd0;
		end else if (run_q) begin
			// keep the difference when no borrow
			r_q <= trial[64] ? shifted[63:0] : trial[63:0];
			q_q <= {q_q[62:0], ~trial[64]};
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule
`default_nettype wire

// ----- rtl/core/decimal_scaled_arith_unit.sv -----
// Top level of the decimal scaled arithmetic unit: sequencer and operand registers.
// Depends on dsau_pkg, dsau_mul and dsau_div.
//
// Usage: drive cmd and both operands and raise start; the command transfers at
// a rising edge where start is high and busy is low. Busy stays high until the
// result is ready. The result then sits on res_*, compare_true, overflow and
// divide_by_zero, and done is high for exactly one cycle; the result transfers
// at the edge that ends that cycle. The receiver cannot stall the unit.
// Unused command codes return an all-zero result.
// The work is set by the two shared units: the 64x64 multiplier forms each
// product from four 32x32 partial products plus accumulate, the divider one
// quotient bit a cycle. Scaling both operands costs four products. Compare ends
// there; add and subtract add one normalizing divide; multiply adds a product
// and up to two divides; divide adds two products, the quotient and one
// normalizing divide. One command is in flight at a time.
// Reset clears the sequencer and flags; no result is emitted for a command
// cut off by reset.
`default_nettype none
module decimal_scaled_arith_unit import dsau_pkg::*; #(
	parameter int FRACTION_PRECISION = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  cmd,
	input  wire logic        a_negative,
	input  wire logic [62:0] a_integer,
	input  wire logic [49:0] a_fraction,
	input  wire logic [3:0]  a_digits,
	input  wire logic        b_negative,
	input  wire logic [62:0] b_integer,
	input  wire logic [49:0] b_fraction,
	input  wire logic [3:0]  b_digits,
	output logic             done,
	output logic             res_negative,
	output logic [62:0]      res_integer,
	output logic [49:0]      res_fraction,
	output logic [3:0]       res_digits,
	output logic             compare_true,
	output logic             overflow,
	output logic             divide_by_zero
);

	localparam logic [5:0] FP6 = 6'(FRACTION_PRECISION);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_SC_M1   = 5'd1;
	localparam logic [4:0] ST_SC_W1   = 5'd2;
	localparam logic [4:0] ST_SC_M2   = 5'd3;
	localparam logic [4:0] ST_SC_W2   = 5'd4;
	localparam logic [4:0] ST_OPS     = 5'd5;
	localparam logic [4:0] ST_MUL_W   = 5'd6;
	localparam logic [4:0] ST_NUM_W   = 5'd7;
	localparam logic [4:0] ST_DEN_M   = 5'd8;
	localparam logic [4:0] ST_DEN_W   = 5'd9;
	localparam logic [4:0] ST_QUO_M   = 5'd10;
	localparam logic [4:0] ST_QUO_W   = 5'd11;
	localparam logic [4:0] ST_FIN     = 5'd12;
	localparam logic [4:0] ST_TRUNC_W = 5'd13;
	localparam logic [4:0] ST_SPLIT_M = 5'd14;
	localparam logic [4:0] ST_SPLIT_W = 5'd15;
	localparam logic [4:0] ST_EMIT    = 5'd16;

	logic [4:0]  state_q;
	logic        done_q;

	// captured command and operands
	logic [3:0]  cmd_q;
	logic        an_q, bn_q;
	logic [62:0] ai_q, bi_q;
	logic [49:0] af_q, bf_q;
	logic [3:0]  ad_q, bd_q, dm_q;
	logic        sel_q;

	// working values
	logic [63:0] t1_q, va_q, vb_q, num_q, den_q, val_q, mag_q;
	logic [5:0]  fd_q, dig_q;
	logic        neg_q;
	logic        ov_q, dz_q, ct_q;
	logic        rneg_q;
	logic [62:0] rint_q;
	logic [49:0] rfrac_q;
	logic [3:0]  rdig_q;

	arith_req_t   mul_req, div_req;
	logic         mul_done, div_done;
	logic [127:0] mul_prod;
	logic [63:0]  div_quot, div_rem;

	// scaling control for the operand being scaled
	logic        aligned_cmd;
	logic [3:0]  sc_off, sc_d;
	logic [5:0]  frac_exp;
	logic [5:0]  num_exp;
	logic [5:0]  trunc_k;
	logic [63:0] fin_mag;

	// scaling arithmetic
	logic        sc_neg;
	logic [63:0] t2, sc_sum, sc_val;
	logic        sc_ov;

	// add / subtract
	logic [63:0] as_res;
	logic        as_ov;

	logic        prod_neg, quo_neg;
	logic [63:0] prod_val, num_val, den_val, quo_val;

	assign aligned_cmd = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB) || (cmd_q >= CMD_EQ);
	assign sc_off      = sel_q ? bd_q : ad_q;
	assign sc_d        = aligned_cmd ? dm_q : sc_off;
	assign frac_exp    = {2'd0, sc_d} - {2'd0, sc_off};
	assign num_exp     = FP6 + {2'd0, bd_q};
	assign trunc_k     = (fd_q > FP6) ? (fd_q - FP6) : 6'd0;
	assign fin_mag     = mag_of(val_q);

	dsau_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	dsau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// requests to the shared units
	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			ST_SC_M1: begin
				mul_req.start = 1'b1;
				mul_req.a     = {1'b0, sel_q ? bi_q : ai_q};
				mul_req.b     = POW10[{2'd0, sc_d}];
			end
			ST_SC_M2: begin
				mul_req.start = 1'b1;
				mul_req.a     = {14'd0, sel_q ? bf_q : af_q};
				mul_req.b     = POW10[frac_exp];
			end
			ST_OPS: begin
				if (cmd_q == CMD_MUL) begin
					mul_req.start = 1'b1;
					mul_req.a     = mag_of(va_q);
					mul_req.b     = mag_of(vb_q);
				end else if (cmd_q == CMD_DIV && vb_q != 64'd0) begin
					mul_req.start = 1'b1;
					mul_req.a     = mag_of(va_q);
					mul_req.b     = POW10[num_exp];
				end
			end
			ST_DEN_M: begin
				mul_req.start = 1'b1;
				mul_req.a     = mag_of(vb_q);
				mul_req.b     = POW10[{2'd0, ad_q}];
			end
			ST_QUO_M: begin
				div_req.start = 1'b1;
				div_req.a     = mag_of(num_q);
				div_req.b     = mag_of(den_q);
			end
			ST_FIN: begin
				// drop the extra digits in one divide when 10^k still fits
				if (trunc_k != 6'd0 && trunc_k <= POW_MAX_EXP) begin
					div_req.start = 1'b1;
					div_req.a     = fin_mag;
					div_req.b     = POW10[trunc_k];
				end
			end
			ST_SPLIT_M: begin
				div_req.start = 1'b1;
				div_req.a     = mag_q;
				div_req.b     = POW10[dig_q];
			end
			default: begin
				mul_req = '0;
				div_req = '0;
			end
		endcase
	end

	// datapath helpers
	always_comb begin
		t2     = mul_prod[63:0];
		sc_neg = sel_q ? bn_q : an_q;
		sc_sum = t1_q + t2;
		sc_ov  = mul_ovf(mul_prod, 1'b0)
			|| ((~(t1_q[63] ^ t2[63])) & (t1_q[63] ^ sc_sum[63]));
		sc_val = sc_sum;
		if (sc_neg) begin
			sc_val = 64'd0 - sc_sum;
			if (sc_sum == SIGN_BIT)
				sc_ov = 1'b1;
		end

		if (cmd_q == CMD_SUB) begin
			as_res = va_q - vb_q;
			as_ov  = (va_q[63] ^ vb_q[63]) & (va_q[63] ^ as_res[63]);
		end else begin
			as_res = va_q + vb_q;
			as_ov  = (~(va_q[63] ^ vb_q[63])) & (va_q[63] ^ as_res[63]);
		end

		prod_neg = va_q[63] ^ vb_q[63];
		prod_val = prod_neg ? (64'd0 - mul_prod[63:0]) : mul_prod[63:0];
		num_val  = va_q[63] ? (64'd0 - mul_prod[63:0]) : mul_prod[63:0];
		den_val  = vb_q[63] ? (64'd0 - mul_prod[63:0]) : mul_prod[63:0];
		quo_neg  = num_q[63] ^ den_q[63];
		quo_val  = quo_neg ? (64'd0 - div_quot) : div_quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			ov_q    <= 1'b0;
			dz_q    <= 1'b0;
			ct_q    <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ov_q  <= 1'b0;
						dz_q  <= 1'b0;
						ct_q  <= 1'b0;
						sel_q <= 1'b0;
						state_q <= (cmd > CMD_LE) ? ST_EMIT : ST_SC_M1;
					end
				end
				ST_SC_M1: state_q <= ST_SC_W1;
				ST_SC_W1: begin
					if (mul_done) begin
						if (mul_ovf(mul_prod, 1'b0))
							ov_q <= 1'b1;
						state_q <= ST_SC_M2;
					end
				end
				ST_SC_M2: state_q <= ST_SC_W2;
				ST_SC_W2: begin
					if (mul_done) begin
						if (sc_ov)
							ov_q <= 1'b1;
						sel_q   <= 1'b1;
						state_q <= sel_q ? ST_OPS : ST_SC_M1;
					end
				end
				ST_OPS: begin
					case (cmd_q)
						CMD_ADD, CMD_SUB: begin
							if (as_ov)
								ov_q <= 1'b1;
							state_q <= ST_FIN;
						end
						CMD_MUL: state_q <= ST_MUL_W;
						CMD_DIV: begin
							if (vb_q == 64'd0) begin
								dz_q    <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								if (num_exp > POW_MAX_EXP)
									ov_q <= 1'b1;
								state_q <= ST_NUM_W;
							end
						end
						CMD_EQ: begin
							ct_q    <= (va_q == vb_q);
							state_q <= ST_EMIT;
						end
						CMD_GT: begin
							ct_q    <= ($signed(vb_q) < $signed(va_q));
							state_q <= ST_EMIT;
						end
						CMD_LT: begin
							ct_q    <= ($signed(va_q) < $signed(vb_q));
							state_q <= ST_EMIT;
						end
						CMD_GE: begin
							ct_q    <= !($signed(va_q) < $signed(vb_q));
							state_q <= ST_EMIT;
						end
						default: begin
							ct_q    <= !($signed(vb_q) < $signed(va_q));
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_MUL_W: begin
					if (mul_done) begin
						if (mul_ovf(mul_prod, prod_neg))
							ov_q <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_NUM_W: begin
					if (mul_done) begin
						if (mul_ovf(mul_prod, va_q[63]))
							ov_q <= 1'b1;
						state_q <= ST_DEN_M;
					end
				end
				ST_DEN_M: state_q <= ST_DEN_W;
				ST_DEN_W: begin
					if (mul_done) begin
						if (mul_ovf(mul_prod, vb_q[63]))
							ov_q <= 1'b1;
						if (den_val == 64'd0) begin
							dz_q    <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_QUO_M;
						end
					end
				end
				ST_QUO_M: state_q <= ST_QUO_W;
				ST_QUO_W: begin
					if (div_done) begin
						if (div_quot > (quo_neg ? SIGN_BIT : MASK63))
							ov_q <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (trunc_k != 6'd0 && trunc_k <= POW_MAX_EXP)
						state_q <= ST_TRUNC_W;
					else
						state_q <= ST_SPLIT_M;
				end
				ST_TRUNC_W: begin
					if (div_done)
						state_q <= ST_SPLIT_M;
				end
				ST_SPLIT_M: state_q <= ST_SPLIT_W;
				ST_SPLIT_W: begin
					if (div_done) begin
						// only an integer part of 2^63 can get here
						if (div_quot[63])
							ov_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q   <= cmd;
					an_q    <= a_negative;
					ai_q    <= a_integer;
					af_q    <= a_fraction;
					ad_q    <= a_digits;
					bn_q    <= b_negative;
					bi_q    <= b_integer;
					bf_q    <= b_fraction;
					bd_q    <= b_digits;
					dm_q    <= (a_digits > b_digits) ? a_digits : b_digits;
					rneg_q  <= 1'b0;
					rint_q  <= 63'd0;
					rfrac_q <= 50'd0;
					rdig_q  <= 4'd0;
				end
			end
			ST_SC_W1: begin
				if (mul_done)
					t1_q <= mul_prod[63:0];
			end
			ST_SC_W2: begin
				if (mul_done) begin
					if (sel_q)
						vb_q <= sc_val;
					else
						va_q <= sc_val;
				end
			end
			ST_OPS: begin
				val_q <= as_res;
				fd_q  <= {2'd0, dm_q};
			end
			ST_MUL_W: begin
				val_q <= prod_val;
				fd_q  <= {2'd0, ad_q} + {2'd0, bd_q};
			end
			ST_NUM_W: num_q <= num_val;
			ST_DEN_W: den_q <= den_val;
			ST_QUO_W: begin
				val_q <= quo_val;
				fd_q  <= FP6;
			end
			ST_FIN: begin
				neg_q <= val_q[63];
				dig_q <= (fd_q > FP6) ? FP6 : fd_q;
				// every digit drops out when 10^k exceeds 64 bits
				mag_q <= (trunc_k > POW_MAX_EXP) ? 64'd0 : fin_mag;
			end
			ST_TRUNC_W: begin
				if (div_done)
					mag_q <= div_quot;
			end
			ST_SPLIT_W: begin
				if (div_done) begin
					rneg_q  <= neg_q && (mag_q != 64'd0);
					rint_q  <= div_quot[62:0];
					rfrac_q <= div_rem[49:0];
					rdig_q  <= dig_q[3:0];
				end
			end
			default: begin
				t1_q <= t1_q;
			end
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign res_negative   = rneg_q;
	assign res_integer    = rint_q;
	assign res_fraction   = rfrac_q;
	assign res_digits     = rdig_q;
	assign compare_true   = ct_q;
	assign overflow       = ov_q;
	assign divide_by_zero = dz_q;

	// the strobe only comes with the sequencer back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// every transfer starts a command
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer did not start the sequencer");

	// a zero magnitude never carries a sign; a wrapped 2^63 integer part may
	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !overflow) |->
			!(res_negative && res_integer == 63'd0 && res_fraction == 50'd0))
		else $error("negative zero result");

	// divide by zero yields a zero number
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> (res_integer == 63'd0 && res_fraction == 50'd0
			&& !res_negative && res_digits == 4'd0))
		else $error("divide by zero result not zero");

endmodule
`default_nettype wire
